/* sv/tpfr_pkg.sv */
// ----------------------------------------------------------------------------
// tpfr_pkg
// Types and codes shared by the parent-first reorder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package tpfr_pkg;

  localparam int NODE_BITS = 10;
  localparam int TAG_W     = 32;
  localparam int SLOT_BITS = 6;
  localparam logic [SLOT_BITS-1:0] NO_SLOT = 6'd63;

  typedef enum logic [2:0] {
    ST_ROW    = 3'd0,
    ST_FIN_OK = 3'd1,
    ST_SELF   = 3'd2,
    ST_DUP    = 3'd3,
    ST_ORPHAN = 3'd4,
    ST_FULL   = 3'd5
  } status_t;

  localparam logic CMD_ROW    = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic                 command;
    logic [NODE_BITS-1:0] node_id;
    logic                 has_parent;
    logic [NODE_BITS-1:0] parent_id;
    logic [TAG_W-1:0]     row_tag;
  } in_word_t;

  typedef struct packed {
    logic [TAG_W-1:0]     out_tag;
    logic [NODE_BITS-1:0] out_node;
    status_t              status;
    logic                 last;
  } out_word_t;

  typedef struct packed {
    logic                 finish;
    logic                 self_par;
    logic                 has_parent;
    logic [NODE_BITS-1:0] node;
    logic [NODE_BITS-1:0] parent;
    logic [TAG_W-1:0]     tag;
  } item_t;

  typedef struct packed {
    logic                 seen;
    logic                 outd;
    logic [SLOT_BITS-1:0] fw;
  } nent_t;

endpackage

`default_nettype wire

/* sv/tpfr_fifo.sv */
// ----------------------------------------------------------------------------
// tpfr_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfr_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output logic      [W-1:0] dout,
  output logic              full,
  output logic              empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      end
      if (do_pop) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end
endmodule

`default_nettype wire

/* sv/tpfr_front.sv */
// ----------------------------------------------------------------------------
// tpfr_front
// Accept words, fold node numbers, flag self parents, queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfr_front #(
  parameter int NODE_COUNT = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              ready,
  input  wire logic              in_push,
  input  wire tpfr_pkg::in_word_t in_word,
  output logic                   in_full,
  input  wire logic              item_pop,
  output tpfr_pkg::item_t        item,
  output logic                   item_empty
);
  import tpfr_pkg::*;

  function automatic logic [NODE_BITS-1:0] fold(input logic [NODE_BITS-1:0] v);
    logic [31:0] r;
    logic [31:0] d;
    r = 32'(v);
    for (int k = NODE_BITS-1; k >= 0; k--) begin
      d = 32'(NODE_COUNT) << k;
      if (r >= d) r = r - d;
    end
    return r[NODE_BITS-1:0];
  endfunction

  item_t cls;
  logic  q_full;

  always_comb begin
    cls.finish     = (in_word.command == CMD_FINISH);
    cls.has_parent = in_word.has_parent;
    cls.node       = fold(in_word.node_id);
    cls.parent     = fold(in_word.parent_id);
    cls.tag        = in_word.row_tag;
    cls.self_par   = in_word.has_parent && (cls.node == cls.parent);
  end

  assign in_full = q_full || !ready;

  tpfr_fifo #(.W($bits(item_t)), .DEPTH(2)) u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push && !in_full),
    .din   (cls),
    .pop   (item_pop),
    .dout  (item),
    .full  (q_full),
    .empty (item_empty)
  );
endmodule

`default_nettype wire

/* sv/tpfr_back.sv */
// ----------------------------------------------------------------------------
// tpfr_back
// Node table, hold store and release sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfr_back #(
  parameter int NODE_COUNT = 1024,
  parameter int HOLD_DEPTH = 63,
  parameter int TAG_BITS   = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  output logic                   ready,
  input  wire tpfr_pkg::item_t   item,
  input  wire logic              item_empty,
  output logic                   item_pop,
  output logic                   oq_push,
  output tpfr_pkg::out_word_t    oq_data,
  input  wire logic              oq_full
);
  import tpfr_pkg::*;

  localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int TW = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;

  typedef struct packed {
    logic [TW-1:0]        tag;
    logic [NODE_BITS-1:0] node;
    logic [SLOT_BITS-1:0] nxt;
  } hent_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_EVAL, S_SEEN, S_WALK, S_WNXT, S_POP, S_REL1, S_REL2, S_FLUSH
  } state_t;

  function automatic logic [NW-1:0] idx(input logic [NODE_BITS-1:0] v);
    logic [NW+NODE_BITS-1:0] e;
    e = (NW+NODE_BITS)'(v);
    return e[NW-1:0];
  endfunction

  nent_t nmem [NODE_COUNT];
  hent_t hmem [HOLD_DEPTH];
  logic [SLOT_BITS-1:0] rq [2**SLOT_BITS];

  state_t               state_r;
  item_t                it_r;
  status_t              err_r;
  logic [6:0]           hc_r;
  logic [HOLD_DEPTH-1:0] free_r;
  logic [SLOT_BITS-1:0] cur_r, fw_r, rq_q;
  logic [NODE_BITS-1:0] rn_r;
  logic [SLOT_BITS-1:0] wp_r, rp_r;
  logic                 clr_r;
  logic [NW-1:0]        clr_addr_r;
  out_word_t            pend_r;
  logic                 pend_v_r;
  nent_t                n0_q, n1_q;
  hent_t                hq;

  logic [NW-1:0]        ra0, ra1, nwa;
  logic                 nwe;
  nent_t                nwd;
  logic                 hwe;
  logic [SLOT_BITS-1:0] ha, hwa;
  hent_t                hwd;
  logic                 prod;
  out_word_t            prod_w;
  logic                 rq_push, rq_pop, rq_empty;
  logic [SLOT_BITS-1:0] free_slot;
  logic                 any_free;

  assign ready    = !clr_r;
  assign rq_empty = (wp_r == rp_r);
  assign any_free = |free_r;

  always_comb begin
    free_slot = NO_SLOT;
    for (int i = HOLD_DEPTH-1; i >= 0; i--) begin
      if (free_r[i]) free_slot = SLOT_BITS'(i);
    end
  end

  always_comb begin
    item_pop = (state_r == S_IDLE) && !item_empty && !clr_r;
    ra0      = idx(it_r.node);
    ra1      = idx(it_r.parent);
    nwe      = 1'b0;
    nwa      = idx(it_r.node);
    nwd      = '{seen: 1'b1, outd: 1'b1, fw: NO_SLOT};
    hwe      = 1'b0;
    hwa      = free_slot;
    hwd      = '{tag: it_r.tag[TW-1:0], node: it_r.node, nxt: n1_q.fw};
    ha       = cur_r;
    prod     = 1'b0;
    prod_w   = '{out_tag: '0, out_node: '0, status: err_r, last: 1'b0};
    rq_push  = 1'b0;
    rq_pop   = 1'b0;
    oq_push  = 1'b0;
    oq_data  = pend_r;
    oq_data.last = 1'b0;
    case (state_r)
      S_CMD: begin
        if (!oq_full) begin
          prod = 1'b1;
          if (err_r != ST_ROW) begin
            prod_w.status = err_r;
          end else if (it_r.finish) begin
            prod_w.status = (hc_r != '0) ? ST_ORPHAN : ST_FIN_OK;
          end else if (it_r.self_par) begin
            prod_w.status = ST_SELF;
          end else begin
            prod = 1'b0;
          end
        end
      end
      S_EVAL: begin
        if (n0_q.seen) begin
          prod = 1'b1;
          prod_w.status = ST_DUP;
        end else if (it_r.has_parent && !n1_q.outd) begin
          if (!any_free) begin
            prod = 1'b1;
            prod_w.status = ST_FULL;
          end else begin
            hwe = 1'b1;
            nwe = 1'b1;
            nwa = idx(it_r.parent);
            nwd = '{seen: n1_q.seen, outd: n1_q.outd, fw: free_slot};
          end
        end else begin
          nwe  = 1'b1;
          prod = 1'b1;
          prod_w = '{out_tag: TAG_W'(it_r.tag[TW-1:0]), out_node: it_r.node,
                     status: ST_ROW, last: 1'b0};
        end
      end
      S_SEEN: begin
        nwe = 1'b1;
        nwd = '{seen: 1'b1, outd: 1'b0, fw: fw_r};
      end
      S_WALK: begin
        if (cur_r >= SLOT_BITS'(HOLD_DEPTH)) begin
          rq_pop = !rq_empty && !oq_full;
        end else begin
          rq_push = 1'b1;
        end
      end
      S_POP: begin
        ha = rq_q;
      end
      S_REL1: begin
        ra0    = idx(hq.node);
        prod   = 1'b1;
        prod_w = '{out_tag: TAG_W'(hq.tag), out_node: hq.node,
                   status: ST_ROW, last: 1'b0};
      end
      S_REL2: begin
        nwe = 1'b1;
        nwa = idx(rn_r);
        nwd = '{seen: n0_q.seen, outd: 1'b1, fw: NO_SLOT};
      end
      S_FLUSH: begin
        oq_push = !oq_full;
        oq_data.last = 1'b1;
      end
      default: begin
      end
    endcase
    if (prod && pend_v_r) oq_push = 1'b1;
    if (clr_r) begin
      nwe = 1'b1;
      nwa = clr_addr_r;
      nwd = '{seen: 1'b0, outd: 1'b0, fw: NO_SLOT};
    end
  end

  always_ff @(posedge clk) begin
    n0_q <= nmem[ra0];
    n1_q <= nmem[ra1];
    if (nwe) nmem[nwa] <= nwd;
  end

  always_ff @(posedge clk) begin
    hq <= hmem[ha];
    if (hwe) hmem[hwa] <= hwd;
  end

  always_ff @(posedge clk) begin
    if (rq_push) rq[wp_r] <= cur_r;
    if (rq_pop) rq_q <= rq[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      err_r      <= ST_ROW;
      hc_r       <= '0;
      free_r     <= '1;
      wp_r       <= '0;
      rp_r       <= '0;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
      pend_v_r   <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (clr_addr_r == NW'(NODE_COUNT-1)) clr_r <= 1'b0;
      end
      if (rq_push) wp_r <= wp_r + 1'b1;
      if (rq_pop)  rp_r <= rp_r + 1'b1;
      if (prod) begin
        pend_r   <= prod_w;
        pend_v_r <= 1'b1;
      end
      case (state_r)
        S_IDLE: begin
          if (item_pop) begin
            it_r    <= item;
            state_r <= S_CMD;
          end
        end
        S_CMD: begin
          if (!oq_full) begin
            if (prod) begin
              err_r   <= prod_w.status == ST_FIN_OK ? err_r : prod_w.status;
              state_r <= S_FLUSH;
            end else begin
              state_r <= S_EVAL;
            end
          end
        end
        S_EVAL: begin
          if (n0_q.seen) begin
            err_r   <= ST_DUP;
            state_r <= S_FLUSH;
          end else if (it_r.has_parent && !n1_q.outd) begin
            if (!any_free) begin
              err_r   <= ST_FULL;
              state_r <= S_FLUSH;
            end else begin
              free_r[free_slot] <= 1'b0;
              hc_r    <= hc_r + 1'b1;
              fw_r    <= n0_q.fw;
              state_r <= S_SEEN;
            end
          end else begin
            cur_r   <= n0_q.fw;
            state_r <= S_WALK;
          end
        end
        S_SEEN: begin
          state_r <= S_IDLE;
        end
        S_WALK: begin
          if (cur_r >= SLOT_BITS'(HOLD_DEPTH)) begin
            if (rq_empty) begin
              state_r <= S_FLUSH;
            end else if (rq_pop) begin
              state_r <= S_POP;
            end
          end else begin
            state_r <= S_WNXT;
          end
        end
        S_WNXT: begin
          cur_r   <= hq.nxt;
          state_r <= S_WALK;
        end
        S_POP: begin
          state_r <= S_REL1;
        end
        S_REL1: begin
          free_r[rq_q[$clog2(HOLD_DEPTH+1)-1:0]] <= 1'b1;
          if (hc_r != '0) hc_r <= hc_r - 1'b1;
          rn_r    <= hq.node;
          state_r <= S_REL2;
        end
        S_REL2: begin
          cur_r   <= n0_q.fw;
          state_r <= S_WALK;
        end
        S_FLUSH: begin
          if (!oq_full) begin
            pend_v_r <= 1'b0;
            state_r  <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(free_r) + 32'(hc_r)) == HOLD_DEPTH)
    else $error("free map and held count disagree");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!pend_v_r && rq_empty))
    else $error("pending word or release queue left at idle");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !item_pop)
    else $error("item taken during table clear");

  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(err_r) != ST_ROW && $past(rst_n)) |-> (err_r == $past(err_r)))
    else $error("error code changed after latch");
endmodule

`default_nettype wire

/* sv/tree_parent_first_reorder_unit.sv */
// ----------------------------------------------------------------------------
// tree_parent_first_reorder_unit
// Reorders tree rows so each row leaves after its parent.
// ----------------------------------------------------------------------------
// Input channel: push in_word while in_full is low; a word is a row (node,
// optional parent, tag) or a finish command. Output channel: while out_empty
// is low, out_word holds the oldest result; pop takes it.
// A passing row gives itself, then its held descendants breadth first. The
// back end steps through S_CMD, S_EVAL, S_WALK and S_FLUSH for a row with
// nothing waiting; each released row is linked into the release queue
// (S_WALK, S_WNXT), then read out and its node entry updated (S_WALK, S_POP,
// S_REL1, S_REL2). A held row gives no result; a finish, a self parent, a
// latched error, a duplicate or a full hold store gives one result. Items
// are worked one at a time. After reset the node table is cleared one entry
// per cycle with in_full high. The first error is sticky until reset.
// When the receiver stops popping, the two-word output queue fills and the
// sequencer waits; the two-word input queue then fills and in_full rises.
// ----------------------------------------------------------------------------
`default_nettype none

module tree_parent_first_reorder_unit #(
  parameter int NODE_COUNT = 1024,
  parameter int HOLD_DEPTH = 63,
  parameter int TAG_BITS   = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_push,
  input  wire tpfr_pkg::in_word_t in_word,
  output logic                    in_full,
  input  wire logic               out_pop,
  output tpfr_pkg::out_word_t     out_word,
  output logic                    out_empty
);
  import tpfr_pkg::*;

  logic      ready, item_pop, item_empty, oq_push, oq_full;
  item_t     item;
  out_word_t oq_data;

  tpfr_front #(.NODE_COUNT(NODE_COUNT)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .ready      (ready),
    .in_push    (in_push),
    .in_word    (in_word),
    .in_full    (in_full),
    .item_pop   (item_pop),
    .item       (item),
    .item_empty (item_empty)
  );

  tpfr_back #(
    .NODE_COUNT (NODE_COUNT),
    .HOLD_DEPTH (HOLD_DEPTH),
    .TAG_BITS   (TAG_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ready      (ready),
    .item       (item),
    .item_empty (item_empty),
    .item_pop   (item_pop),
    .oq_push    (oq_push),
    .oq_data    (oq_data),
    .oq_full    (oq_full)
  );

  tpfr_fifo #(.W($bits(out_word_t)), .DEPTH(2)) u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .din   (oq_data),
    .pop   (out_pop),
    .dout  (out_word),
    .full  (oq_full),
    .empty (out_empty)
  );
endmodule

`default_nettype wire
